// ----- rtl/core/nbpr_pkg.sv -----
`default_nettype none

package nbpr_pkg;

    // Geometry limits
    localparam int MAX_WIDTH    = 1024;
    localparam int HEIGHT_LIMIT = 4095;
    localparam int MIN_DIM      = 2;

    // Fixed-point formats
    localparam int GAIN_FRAC_BITS   = 16;
    localparam int OFFSET_FRAC_BITS = 8;
    localparam int OFFSET_SHIFT     = GAIN_FRAC_BITS - OFFSET_FRAC_BITS;

    // Field widths
    localparam int PIX_W      = 16;
    localparam int GAIN_W     = 24;
    localparam int OFFSET_W   = 32;
    localparam int AW_CFG_W   = 11;
    localparam int AH_CFG_W   = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 1;

    // Derived widths
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = $clog2(HEIGHT_LIMIT + 1);
    localparam int PROD_W = PIX_W + 1 + GAIN_W;
    localparam int SUM_W  = ((PROD_W > OFFSET_W + OFFSET_SHIFT) ?
                             PROD_W : OFFSET_W + OFFSET_SHIFT) + 1;

    // Neighbour mean
    localparam int NEIGH_COUNT = 8;
    localparam int NSUM_W      = PIX_W + 3;
    localparam int SHIFT_BY_8  = 3;
    localparam int RECIP_SHIFT = 21;
    localparam int RECIP_W     = 20;
    localparam int MEAN_W      = NSUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'(((1 << RECIP_SHIFT) + 2) / 3);
    localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_W'(((1 << RECIP_SHIFT) + 4) / 5);

    // Saturation limits of the calibrated sum (GAIN_FRAC_BITS fraction bits)
    localparam logic signed [SUM_W-1:0] SAT_LOW  = -(SUM_W'(1) << GAIN_FRAC_BITS);
    localparam logic signed [SUM_W-1:0] SAT_HIGH = SUM_W'(1) << (GAIN_FRAC_BITS + PIX_W);

    // Register reset values
    localparam logic [AW_CFG_W-1:0] ACTIVE_WIDTH_RESET  = AW_CFG_W'(640);
    localparam logic [AH_CFG_W-1:0] ACTIVE_HEIGHT_RESET = AH_CFG_W'(512);

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_FLUSH = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_WIDTH  = 1'b0,
        REG_ACTIVE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DIV_BY_3 = 2'd0,
        DIV_BY_5 = 2'd1,
        DIV_BY_8 = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0]   gain;
        logic signed [OFFSET_W-1:0] offset;
        logic                       bad;
        logic                       valid;
    } calib_t;

    typedef struct packed {
        logic [PIX_W-1:0] above;
        logic [PIX_W-1:0] centre;
        logic [PIX_W-1:0] below;
    } column_t;

    typedef struct packed {
        logic        en;
        logic        clear;
    } pipe_ctrl_t;

    typedef struct packed {
        logic [WID_W-1:0] width;
        logic [ROW_W-1:0] height;
    } geom_t;

    typedef struct packed {
        logic    vld;
        column_t col;
        calib_t  calib;
    } stage_a_t;

    typedef struct packed {
        logic                       vld;
        logic                       bad;
        logic signed [PROD_W-1:0]   product;
        logic signed [OFFSET_W-1:0] offset;
        logic [NSUM_W-1:0]          nsum;
        div_sel_t                   div_sel;
        logic                       frame_end;
    } stage_b_t;

    function automatic logic [WID_W-1:0] eff_width(input logic [AW_CFG_W-1:0] aw);
        int w;
        w = int'(aw);
        if (w < MIN_DIM) w = MIN_DIM;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return WID_W'(w);
    endfunction

    function automatic logic [ROW_W-1:0] eff_height(input logic [AH_CFG_W-1:0] ah);
        int h;
        h = int'(ah);
        if (h < MIN_DIM) h = MIN_DIM;
        if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
        return ROW_W'(h);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/nbpr_stream_if.sv -----
`default_nettype none

// Pixel request channel
interface nbpr_in_if;
    logic                                 valid;
    logic                                 ready;
    nbpr_pkg::cmd_t                       command;
    logic [nbpr_pkg::PIX_W-1:0]           raw_pixel;
    logic signed [nbpr_pkg::GAIN_W-1:0]   pixel_gain;
    logic signed [nbpr_pkg::OFFSET_W-1:0] pixel_offset;
    logic                                 bad_flag;

    modport source (
        output valid, command, raw_pixel, pixel_gain, pixel_offset, bad_flag,
        input  ready
    );
    modport sink (
        input  valid, command, raw_pixel, pixel_gain, pixel_offset, bad_flag,
        output ready
    );
endinterface

// Corrected pixel channel
interface nbpr_out_if;
    logic                       valid;
    logic                       ready;
    logic [nbpr_pkg::PIX_W-1:0] corrected_pixel;
    logic                       was_replaced;
    logic                       was_saturated;
    logic                       frame_end;

    modport source (
        output valid, corrected_pixel, was_replaced, was_saturated, frame_end,
        input  ready
    );
    modport sink (
        input  valid, corrected_pixel, was_replaced, was_saturated, frame_end,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/nbpr_line_buf.sv -----
`default_nettype none

// Two raw line buffers and one calibration line buffer, circular over the
// active width. Read data is registered and forms stage A of the pipeline.
module nbpr_line_buf (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire nbpr_pkg::pipe_ctrl_t         ctrl,
    input  wire nbpr_pkg::geom_t              geom,
    input  wire logic                         step,
    input  wire logic [nbpr_pkg::PIX_W-1:0]   wr_raw,
    input  wire nbpr_pkg::calib_t             wr_calib,
    output nbpr_pkg::stage_a_t                stage_a
);

    logic [nbpr_pkg::PIX_W-1:0] line_one_mem [nbpr_pkg::MAX_WIDTH];
    logic [nbpr_pkg::PIX_W-1:0] line_two_mem [nbpr_pkg::MAX_WIDTH];
    nbpr_pkg::calib_t           calib_mem    [nbpr_pkg::MAX_WIDTH];

    logic [nbpr_pkg::COL_W-1:0] sc_reg, sc_next;
    logic [nbpr_pkg::WID_W-1:0] sc_inc;
    logic                       sc_wrap;
    logic                       filled_reg;
    logic                       rd_ok_reg;
    logic                       vld_reg;
    logic                       two_pend_reg;
    logic [nbpr_pkg::COL_W-1:0] two_addr_reg;

    logic [nbpr_pkg::PIX_W-1:0] above_rd_reg;
    logic [nbpr_pkg::PIX_W-1:0] centre_rd_reg;
    logic [nbpr_pkg::PIX_W-1:0] below_reg;
    nbpr_pkg::calib_t           calib_rd_reg;

    // Stream column wraps at the active width
    assign sc_inc  = nbpr_pkg::WID_W'(sc_reg) + nbpr_pkg::WID_W'(1);
    assign sc_wrap = (sc_inc >= geom.width);
    assign sc_next = sc_wrap ? '0 : sc_inc[nbpr_pkg::COL_W-1:0];

    // Control: column pointer, first-line fill flag, pending line-two write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_reg       <= '0;
            filled_reg   <= 1'b0;
            rd_ok_reg    <= 1'b0;
            vld_reg      <= 1'b0;
            two_pend_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            sc_reg       <= '0;
            filled_reg   <= 1'b0;
            rd_ok_reg    <= 1'b0;
            vld_reg      <= 1'b0;
            two_pend_reg <= 1'b0;
        end
        else
        begin
            two_pend_reg <= step;
            if (ctrl.en)
            begin
                vld_reg <= step;
            end
            if (step)
            begin
                sc_reg    <= sc_next;
                rd_ok_reg <= filled_reg;
                if (sc_wrap)
                begin
                    filled_reg <= 1'b1;
                end
            end
        end
    end

    // Memories: read before write at the stream column
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            line_one_mem[sc_reg] <= wr_raw;
            calib_mem[sc_reg]    <= wr_calib;
            centre_rd_reg        <= line_one_mem[sc_reg];
            above_rd_reg         <= line_two_mem[sc_reg];
            calib_rd_reg         <= calib_mem[sc_reg];
            below_reg            <= wr_raw;
            two_addr_reg         <= sc_reg;
        end
        // line two takes the value line one held, written in the cycle after the read
        if (two_pend_reg)
        begin
            line_two_mem[two_addr_reg] <= centre_rd_reg;
        end
    end

    // Entries not yet written since clear carry no valid request
    always_comb
    begin
        stage_a.vld              = vld_reg;
        stage_a.col.above        = above_rd_reg;
        stage_a.col.centre       = centre_rd_reg;
        stage_a.col.below        = below_reg;
        stage_a.calib            = calib_rd_reg;
        stage_a.calib.valid      = calib_rd_reg.valid & rd_ok_reg;
    end

endmodule

`default_nettype wire

// ----- rtl/core/nbpr_window.sv -----
`default_nettype none

// 3x3 raw window, centre calibration latch and output raster position.
// Computes the gain product and the masked neighbour sum into stage B.
module nbpr_window (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire nbpr_pkg::pipe_ctrl_t ctrl,
    input  wire nbpr_pkg::geom_t      geom,
    input  wire nbpr_pkg::stage_a_t   stage_a,
    output nbpr_pkg::stage_b_t        stage_b
);

    // Oldest and middle window columns; the newest column comes from stage A
    logic [nbpr_pkg::PIX_W-1:0] win_mid_reg [3];
    logic [nbpr_pkg::PIX_W-1:0] win_new_reg [3];
    nbpr_pkg::calib_t           latch_reg;
    logic [nbpr_pkg::COL_W-1:0] out_col_reg;
    logic [nbpr_pkg::ROW_W-1:0] out_row_reg;
    nbpr_pkg::stage_b_t         b_reg;

    logic                        shift;
    logic                        emit;
    logic [nbpr_pkg::WID_W-1:0]  col_inc;
    logic [nbpr_pkg::ROW_W:0]    row_inc;
    logic                        at_top, at_bottom, at_left, at_right;
    logic [nbpr_pkg::PIX_W-1:0]  nb [nbpr_pkg::NEIGH_COUNT];
    logic [nbpr_pkg::NEIGH_COUNT-1:0] nb_use;
    logic [nbpr_pkg::NSUM_W-1:0] nsum;
    nbpr_pkg::div_sel_t          div_sel;
    logic signed [nbpr_pkg::PROD_W-1:0] product;

    assign shift = ctrl.en & stage_a.vld;
    assign emit  = shift & latch_reg.valid;

    // Border flags from the output raster position
    assign col_inc   = nbpr_pkg::WID_W'(out_col_reg) + nbpr_pkg::WID_W'(1);
    assign row_inc   = (nbpr_pkg::ROW_W + 1)'(out_row_reg) + (nbpr_pkg::ROW_W + 1)'(1);
    assign at_top    = (out_row_reg == '0);
    assign at_bottom = (row_inc >= (nbpr_pkg::ROW_W + 1)'(geom.height));
    assign at_left   = (out_col_reg == '0);
    assign at_right  = (col_inc >= geom.width);

    // Neighbours of the centre after this shift
    always_comb
    begin
        nb[0] = win_mid_reg[0];
        nb[1] = win_new_reg[0];
        nb[2] = stage_a.col.above;
        nb[3] = win_mid_reg[1];
        nb[4] = stage_a.col.centre;
        nb[5] = win_mid_reg[2];
        nb[6] = win_new_reg[2];
        nb[7] = stage_a.col.below;
        nb_use[0] = !at_top && !at_left;
        nb_use[1] = !at_top;
        nb_use[2] = !at_top && !at_right;
        nb_use[3] = !at_left;
        nb_use[4] = !at_right;
        nb_use[5] = !at_bottom && !at_left;
        nb_use[6] = !at_bottom;
        nb_use[7] = !at_bottom && !at_right;
    end

    always_comb
    begin
        nsum = '0;
        for (int i = 0; i < nbpr_pkg::NEIGH_COUNT; i++)
        begin
            if (nb_use[i])
            begin
                nsum = nsum + nbpr_pkg::NSUM_W'(nb[i]);
            end
        end
    end

    // Corners use three neighbours, edges five, the interior eight
    always_comb
    begin
        priority if ((at_top || at_bottom) && (at_left || at_right))
        begin
            div_sel = nbpr_pkg::DIV_BY_3;
        end
        else if (at_top || at_bottom || at_left || at_right)
        begin
            div_sel = nbpr_pkg::DIV_BY_5;
        end
        else
        begin
            div_sel = nbpr_pkg::DIV_BY_8;
        end
    end

    assign product = $signed({1'b0, win_new_reg[1]}) * $signed(latch_reg.gain);

    // Window and latch advance on every stream step
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_mid_reg[i] <= win_new_reg[i];
            end
            win_new_reg[0] <= stage_a.col.above;
            win_new_reg[1] <= stage_a.col.centre;
            win_new_reg[2] <= stage_a.col.below;
        end
    end

    // Latch, raster position and stage B register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg   <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            b_reg       <= '0;
        end
        else if (ctrl.clear)
        begin
            latch_reg   <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            b_reg.vld   <= 1'b0;
        end
        else
        begin
            if (shift)
            begin
                latch_reg <= stage_a.calib;
            end
            if (ctrl.en)
            begin
                b_reg.vld <= emit;
            end
            if (emit)
            begin
                b_reg.bad       <= latch_reg.bad;
                b_reg.product   <= product;
                b_reg.offset    <= latch_reg.offset;
                b_reg.nsum      <= nsum;
                b_reg.div_sel   <= div_sel;
                b_reg.frame_end <= at_bottom && at_right;
                if (at_right)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= at_bottom ? '0 : row_inc[nbpr_pkg::ROW_W-1:0];
                end
                else
                begin
                    out_col_reg <= col_inc[nbpr_pkg::COL_W-1:0];
                end
            end
        end
    end

    assign stage_b = b_reg;

endmodule

`default_nettype wire

// ----- rtl/core/nbpr_result.sv -----
`default_nettype none

// Offset add with truncation and clamp, or neighbour mean by reciprocal or shift;
// drives the output register.
module nbpr_result (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire nbpr_pkg::pipe_ctrl_t ctrl,
    input  wire nbpr_pkg::stage_b_t   stage_b,
    nbpr_out_if.source                result
);

    logic signed [nbpr_pkg::SUM_W-1:0] prod_ext;
    logic signed [nbpr_pkg::SUM_W-1:0] off_ext;
    logic signed [nbpr_pkg::SUM_W-1:0] cal_sum;
    logic                              under;
    logic                              over;
    logic [nbpr_pkg::PIX_W-1:0]        cal_pix;
    logic [nbpr_pkg::RECIP_W-1:0]      recip;
    logic [nbpr_pkg::MEAN_W-1:0]       mean_prod;
    logic [nbpr_pkg::PIX_W-1:0]        mean_pix;

    logic                              vld_reg;
    logic [nbpr_pkg::PIX_W-1:0]        pix_reg;
    logic                              replaced_reg;
    logic                              sat_reg;
    logic                              frame_end_reg;

    // Calibrated sum with GAIN_FRAC_BITS fraction bits
    assign prod_ext = nbpr_pkg::SUM_W'(stage_b.product);
    assign off_ext  = nbpr_pkg::SUM_W'($signed(stage_b.offset));
    assign cal_sum  = prod_ext + (off_ext <<< nbpr_pkg::OFFSET_SHIFT);

    // Truncation toward zero: small negatives give zero without clamping
    assign under = (cal_sum <= nbpr_pkg::SAT_LOW);
    assign over  = (cal_sum >= nbpr_pkg::SAT_HIGH);

    always_comb
    begin
        priority if (under)
        begin
            cal_pix = '0;
        end
        else if (over)
        begin
            cal_pix = '1;
        end
        else if (cal_sum < 0)
        begin
            cal_pix = '0;
        end
        else
        begin
            cal_pix = cal_sum[nbpr_pkg::GAIN_FRAC_BITS +: nbpr_pkg::PIX_W];
        end
    end

    // Neighbour mean: reciprocal multiply for three and five, shift for eight
    always_comb
    begin
        unique case (stage_b.div_sel)
            nbpr_pkg::DIV_BY_3: recip = nbpr_pkg::RECIP_3;
            nbpr_pkg::DIV_BY_5: recip = nbpr_pkg::RECIP_5;
            default:            recip = '0;
        endcase
    end

    assign mean_prod = nbpr_pkg::MEAN_W'(stage_b.nsum) * nbpr_pkg::MEAN_W'(recip);
    assign mean_pix  = (stage_b.div_sel == nbpr_pkg::DIV_BY_8) ?
                       stage_b.nsum[nbpr_pkg::SHIFT_BY_8 +: nbpr_pkg::PIX_W] :
                       mean_prod[nbpr_pkg::RECIP_SHIFT +: nbpr_pkg::PIX_W];

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            vld_reg <= 1'b0;
        end
        else if (ctrl.en)
        begin
            vld_reg <= stage_b.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en && stage_b.vld)
        begin
            pix_reg       <= stage_b.bad ? mean_pix : cal_pix;
            replaced_reg  <= stage_b.bad;
            sat_reg       <= !stage_b.bad && (under || over);
            frame_end_reg <= stage_b.frame_end;
        end
    end

    assign result.valid           = vld_reg;
    assign result.corrected_pixel = pix_reg;
    assign result.was_replaced    = replaced_reg;
    assign result.was_saturated   = sat_reg;
    assign result.frame_end       = frame_end_reg;

endmodule

`default_nettype wire

// ----- rtl/core/nuc_bad_pixel_replace_top.sv -----
// Two-point non-uniformity correction with bad-pixel replacement for a
// raster pixel stream. Each pixel request carries its raw sample, a signed
// Q8.16 gain, a signed Q24.8 offset and a bad flag; a good pixel leaves as
// raw*gain + offset truncated toward zero and clamped to 0..65535, a bad one
// as the floored mean of its 8, 5 (edge) or 3 (corner) raw neighbours. The
// block takes one request per clock while its results are taken; a result
// that the receiver does not take holds the whole pipeline, and the request
// side with it, in the same cycle. A result belongs to the pixel one line
// plus one pixel before the request that releases it and reaches the
// output this way: the line buffers are read into a register at the
// accepting edge, the window, gain multiplier and neighbour sum fill the
// next register, and the offset add, clamp and neighbour mean fill the
// output register. Once a frame's last pixel is in, send flush
// requests (command 1) to drain the last line plus one pixel; a flush in
// mid-frame is dropped. Writing active_width or active_height empties the
// pipeline and restarts the raster; there is no clearing pass after reset.
`default_nettype none

module nuc_bad_pixel_replace_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [nbpr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [nbpr_pkg::CFG_DATA_W-1:0]   cfg_data,
    nbpr_in_if.sink                                pixel,
    nbpr_out_if.source                             result
);

    logic [nbpr_pkg::AW_CFG_W-1:0] active_width_reg;
    logic [nbpr_pkg::AH_CFG_W-1:0] active_height_reg;
    logic [nbpr_pkg::COL_W-1:0]    in_col_reg;
    logic [nbpr_pkg::ROW_W-1:0]    in_row_reg;

    nbpr_pkg::pipe_ctrl_t          ctrl;
    nbpr_pkg::geom_t               geom;
    nbpr_pkg::stage_a_t            stage_a;
    nbpr_pkg::stage_b_t            stage_b;
    nbpr_pkg::calib_t              wr_calib;
    logic [nbpr_pkg::PIX_W-1:0]    wr_raw;

    logic                          accept;
    logic                          is_pixel;
    logic                          frame_start;
    logic                          step;
    logic [nbpr_pkg::WID_W-1:0]    in_col_inc;
    logic [nbpr_pkg::ROW_W:0]      in_row_inc;

    // Whole pipeline moves while the output register can take a result
    assign ctrl.en    = !result.valid || result.ready;
    assign ctrl.clear = cfg_wr_en;
    assign pixel.ready = ctrl.en;

    assign geom.width  = nbpr_pkg::eff_width(active_width_reg);
    assign geom.height = nbpr_pkg::eff_height(active_height_reg);

    // Request decode: flushes only step the stream at a frame boundary
    assign accept      = pixel.valid && pixel.ready;
    assign is_pixel    = (pixel.command == nbpr_pkg::CMD_PIXEL);
    assign frame_start = (in_col_reg == '0) && (in_row_reg == '0);
    assign step        = accept && (is_pixel || frame_start);

    always_comb
    begin
        if (is_pixel)
        begin
            wr_raw          = pixel.raw_pixel;
            wr_calib.gain   = pixel.pixel_gain;
            wr_calib.offset = pixel.pixel_offset;
            wr_calib.bad    = pixel.bad_flag;
            wr_calib.valid  = 1'b1;
        end
        else
        begin
            wr_raw   = '0;
            wr_calib = '0;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_width_reg  <= nbpr_pkg::ACTIVE_WIDTH_RESET;
            active_height_reg <= nbpr_pkg::ACTIVE_HEIGHT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (nbpr_pkg::cfg_reg_t'(cfg_index))
                nbpr_pkg::REG_ACTIVE_WIDTH:
                    active_width_reg  <= cfg_data[nbpr_pkg::AW_CFG_W-1:0];
                nbpr_pkg::REG_ACTIVE_HEIGHT:
                    active_height_reg <= cfg_data[nbpr_pkg::AH_CFG_W-1:0];
            endcase
        end
    end

    // Input raster position
    assign in_col_inc = nbpr_pkg::WID_W'(in_col_reg) + nbpr_pkg::WID_W'(1);
    assign in_row_inc = (nbpr_pkg::ROW_W + 1)'(in_row_reg) + (nbpr_pkg::ROW_W + 1)'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
        end
        else if (accept && is_pixel)
        begin
            if (in_col_inc >= geom.width)
            begin
                in_col_reg <= '0;
                if (in_row_inc >= (nbpr_pkg::ROW_W + 1)'(geom.height))
                begin
                    in_row_reg <= '0;
                end
                else
                begin
                    in_row_reg <= in_row_inc[nbpr_pkg::ROW_W-1:0];
                end
            end
            else
            begin
                in_col_reg <= in_col_inc[nbpr_pkg::COL_W-1:0];
            end
        end
    end

    nbpr_line_buf u_line_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .geom     (geom),
        .step     (step),
        .wr_raw   (wr_raw),
        .wr_calib (wr_calib),
        .stage_a  (stage_a)
    );

    nbpr_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .geom    (geom),
        .stage_a (stage_a),
        .stage_b (stage_b)
    );

    nbpr_result u_result (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .stage_b (stage_b),
        .result  (result)
    );

    // A replaced pixel never reports clamping
    a_replaced_not_sat: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.was_replaced && result.was_saturated))
        else $error("replaced pixel flagged as saturated");

    // A mid-frame flush must not advance the line buffers
    a_flush_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_pixel && !frame_start) |=> !stage_a.vld)
        else $error("mid-frame flush stepped the stream");

    // Stage B only fills from a stream step in stage A
    a_b_from_a: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(stage_b.vld) |-> $past(stage_a.vld))
        else $error("stage B filled without a stream step");

endmodule

`default_nettype wire
